// ===== hdl/gws_pkg.sv =====
// Shared types, constants and saturation helper for the wave grid step block.
// Used by gws_mul and grid_wave_spring_step_top; depends on nothing.
`default_nettype none
package gws_pkg;

    // Field widths fixed by the item and register formats
    localparam int DIM_W   = 7;
    localparam int COORD_W = 6;
    localparam int DATA_W  = 32;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W   = PROD_W + 1;
    localparam int WIDE_W  = 72;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SPRING = 2'd2;
    localparam logic [1:0] REG_DAMP   = 2'd3;

    // sqrt(2)/2 in Q2.30
    localparam longint DIAG_Q30 = 64'd759250125;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } clip_t;

    // Clip a wide signed value to 32 signed bits and flag the clip
    function automatic clip_t clip32(input logic signed [WIDE_W-1:0] v);
        clip_t r;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sh7FFF_FFFF);
        lo = -WIDE_W'(64'sh8000_0000);
        if (v > hi)
        begin
            r.sat   = 1'b1;
            r.value = 32'h7FFF_FFFF;
        end
        else if (v < lo)
        begin
            r.sat   = 1'b1;
            r.value = 32'h8000_0000;
        end
        else
        begin
            r.sat   = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/gws_mul.sv =====
// Shared signed multiplier with registered product and round-half-up shift.
// Depends on gws_pkg.
`default_nettype none
module gws_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire gws_pkg::mul_req_t              req,
    output logic signed [gws_pkg::RND_W-1:0]    rnd
);
    import gws_pkg::*;

    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [RND_W-1:0]  biased;

    // Multiply the selected operands
    assign prod_next = req.a * req.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Round half toward plus infinity, then drop the fraction
    assign biased = RND_W'(prod_reg) + HALF;
    assign rnd    = biased >>> FRAC_BITS;

endmodule
`default_nettype wire

// ===== hdl/grid_wave_spring_step_top.sv =====
// Top level of the wave grid step block: sequencer, three grid memories, result register.
// Depends on gws_pkg and gws_mul.
// Throughput: one request at a time; the next is taken once the result is taken.
// The step cost comes from nine reads per cell through one grid read port and the shared multiplier.
// Reset: asynchronous, active low; a clearing pass over all MAX_COLS*MAX_ROWS cells
// (4096 by default) zeroes all grids before the first request is taken.
`default_nettype none
module grid_wave_spring_step_top #(
    parameter int MAX_COLS  = 64,
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation[1:0], cell_x[7:2], cell_y[13:8], write_value[45:14], time_delta[77:46]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value[31:0], saturated[32]
    output logic [39:0]      m_tdata
);
    import gws_pkg::*;

    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam longint WD = (DIAG_Q30 + (64'd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

    typedef enum logic [14:0] {
        ST_CLEAR  = 15'b000000000000001,
        ST_IDLE   = 15'b000000000000010,
        ST_READ   = 15'b000000000000100,
        ST_GATHER = 15'b000000000001000,
        ST_MUL_D  = 15'b000000000010000,
        ST_FORCE  = 15'b000000000100000,
        ST_MUL_S  = 15'b000000001000000,
        ST_MUL_V  = 15'b000000010000000,
        ST_ACCEL  = 15'b000000100000000,
        ST_MUL_A  = 15'b000001000000000,
        ST_VEL    = 15'b000010000000000,
        ST_MUL_N  = 15'b000100000000000,
        ST_NEXT   = 15'b001000000000000,
        ST_COPY   = 15'b010000000000000,
        ST_DONE   = 15'b100000000000000
    } state_t;

    // Configuration registers
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [DATA_W-1:0] spring_reg, damp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            spring_reg <= '0;
            damp_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_SPRING: spring_reg <= cfg_data;
                REG_DAMP:   damp_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Effective dimensions
    logic [DIM_W-1:0] w_eff, h_eff;
    assign w_eff = (32'(width_reg) > MAX_COLS)  ? DIM_W'(MAX_COLS) : width_reg;
    assign h_eff = (32'(height_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : height_reg;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] x,
                                                    input logic [DIM_W-1:0] y,
                                                    input logic [DIM_W-1:0] h);
        logic [2*DIM_W-1:0] p;
        p = (2*DIM_W)'(x) * (2*DIM_W)'(h) + (2*DIM_W)'(y);
        return ADDR_W'(p);
    endfunction

    // Input fields
    logic [1:0]               in_op;
    logic [DIM_W-1:0]         in_x, in_y;
    logic [DATA_W-1:0]        in_wv, in_dt;
    logic                     in_inside;
    logic                     in_fire;
    logic [ADDR_W-1:0]        in_addr;

    assign in_op     = s_tdata[1:0];
    assign in_x      = {1'b0, s_tdata[7:2]};
    assign in_y      = {1'b0, s_tdata[13:8]};
    assign in_wv     = s_tdata[45:14];
    assign in_dt     = s_tdata[77:46];
    assign in_inside = (in_x < w_eff) && (in_y < h_eff);
    assign in_addr   = cell_addr(in_x, in_y, h_eff);

    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_fire  = s_tvalid && s_tready;

    // Sequencer registers
    logic [ADDR_W-1:0]        clr_reg;
    logic [DIM_W-1:0]         x_reg, y_reg;
    logic [3:0]               k_reg;
    logic [DATA_W-1:0]        dt_reg;
    logic                     inside_reg;
    logic                     sat_reg;
    logic signed [33:0]       orth_reg, diag_reg;
    logic signed [DATA_W-1:0] centre_reg, vel_reg, force_reg, accel_reg;
    logic signed [RND_W-1:0]  t_reg;
    logic [CNT_W-1:0]         copy_idx_reg;
    logic                     copy_pend_reg;
    logic [ADDR_W-1:0]        copy_addr_reg;

    // Memory read data
    logic signed [DATA_W-1:0] now_q, next_q, vel_q;

    // Neighbor offsets for gather slot k: rows of three along the first index
    logic [DIM_W-1:0] nbr_x, nbr_y;
    always_comb
    begin
        nbr_x = x_reg;
        nbr_y = y_reg;
        unique case (k_reg)
            4'd0: begin nbr_x = x_reg - 1'b1; nbr_y = y_reg - 1'b1; end
            4'd1: begin nbr_x = x_reg - 1'b1; nbr_y = y_reg;        end
            4'd2: begin nbr_x = x_reg - 1'b1; nbr_y = y_reg + 1'b1; end
            4'd3: begin nbr_x = x_reg;        nbr_y = y_reg - 1'b1; end
            4'd4: begin nbr_x = x_reg;        nbr_y = y_reg;        end
            4'd5: begin nbr_x = x_reg;        nbr_y = y_reg + 1'b1; end
            4'd6: begin nbr_x = x_reg + 1'b1; nbr_y = y_reg - 1'b1; end
            4'd7: begin nbr_x = x_reg + 1'b1; nbr_y = y_reg;        end
            4'd8: begin nbr_x = x_reg + 1'b1; nbr_y = y_reg + 1'b1; end
            default: ;
        endcase
    end

    logic [ADDR_W-1:0] nbr_addr, ctr_addr;
    assign nbr_addr = cell_addr(nbr_x, nbr_y, h_eff);
    assign ctr_addr = cell_addr(x_reg, y_reg, h_eff);

    logic [CNT_W-1:0] copy_len;
    assign copy_len = CNT_W'((2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff));

    // Shared multiplier
    mul_req_t                mreq;
    logic signed [RND_W-1:0] mrnd;
    logic signed [34:0]      orth_adj, diag_adj;

    assign orth_adj = 35'(orth_reg) - $signed({centre_reg[31], centre_reg, 2'b00});
    assign diag_adj = 35'(diag_reg) - $signed({centre_reg[31], centre_reg, 2'b00});

    always_comb
    begin
        mreq.a = '0;
        mreq.b = '0;
        priority case (1'b1)
            (state_reg == ST_MUL_D):
            begin
                mreq.a = MUL_A_W'(diag_adj);
                mreq.b = MUL_B_W'(WD);
            end
            (state_reg == ST_MUL_S):
            begin
                mreq.a = MUL_A_W'(force_reg);
                mreq.b = {1'b0, spring_reg};
            end
            (state_reg == ST_MUL_V):
            begin
                mreq.a = MUL_A_W'(vel_reg);
                mreq.b = {1'b0, damp_reg};
            end
            (state_reg == ST_MUL_A):
            begin
                mreq.a = MUL_A_W'(accel_reg);
                mreq.b = {1'b0, dt_reg};
            end
            (state_reg == ST_MUL_N):
            begin
                mreq.a = MUL_A_W'(vel_reg);
                mreq.b = {1'b0, dt_reg};
            end
            default: ;
        endcase
    end

    gws_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk (clk),
        .req (mreq),
        .rnd (mrnd)
    );

    // Clipped results of each arithmetic step
    clip_t force_c, accel_c, vel_c, nxt_c;
    assign force_c = clip32(WIDE_W'(orth_adj) + WIDE_W'(mrnd));
    assign accel_c = clip32(WIDE_W'(t_reg) - WIDE_W'(mrnd));
    assign vel_c   = clip32(WIDE_W'(vel_reg) + WIDE_W'(mrnd));
    assign nxt_c   = clip32(WIDE_W'(centre_reg) + WIDE_W'(mrnd));

    logic last_y, last_x;
    assign last_y = !((8'(y_reg) + 8'd2) < 8'(h_eff));
    assign last_x = !((8'(x_reg) + 8'd2) < 8'(w_eff));

    // Grid memory ports
    logic                     now_we, next_we, vel_we;
    logic [ADDR_W-1:0]        now_wa, next_wa, vel_wa;
    logic signed [DATA_W-1:0] now_wd, next_wd, vel_wd;
    logic [ADDR_W-1:0]        next_ra;

    always_comb
    begin
        now_we  = 1'b0;
        now_wa  = clr_reg;
        now_wd  = '0;
        next_we = 1'b0;
        next_wa = clr_reg;
        next_wd = '0;
        vel_we  = 1'b0;
        vel_wa  = clr_reg;
        vel_wd  = '0;
        next_ra = copy_idx_reg[ADDR_W-1:0];
        priority case (1'b1)
            (state_reg == ST_CLEAR):
            begin
                now_we  = 1'b1;
                next_we = 1'b1;
                vel_we  = 1'b1;
            end
            (state_reg == ST_IDLE):
            begin
                now_we  = in_fire && (in_op == OP_WRITE) && in_inside;
                now_wa  = in_addr;
                now_wd  = in_wv;
                next_ra = in_addr;
            end
            (state_reg == ST_NEXT):
            begin
                next_we = 1'b1;
                next_wa = ctr_addr;
                next_wd = nxt_c.value;
                vel_we  = 1'b1;
                vel_wa  = ctr_addr;
                vel_wd  = vel_reg;
            end
            (state_reg == ST_COPY):
            begin
                now_we = copy_pend_reg;
                now_wa = copy_addr_reg;
                now_wd = next_q;
            end
            default: ;
        endcase
    end

    logic signed [DATA_W-1:0] now_mem  [CELLS];
    logic signed [DATA_W-1:0] next_mem [CELLS];
    logic signed [DATA_W-1:0] vel_mem  [CELLS];

    always_ff @(posedge clk)
    begin
        if (now_we)
        begin
            now_mem[now_wa] <= now_wd;
        end
        now_q <= now_mem[nbr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_q <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
        begin
            vel_mem[vel_wa] <= vel_wd;
        end
        vel_q <= vel_mem[ctr_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:
                if (in_fire)
                begin
                    if (in_op == OP_READ)
                        state_next = ST_READ;
                    else if (in_op == OP_STEP)
                        state_next = (w_eff >= 7'd3 && h_eff >= 7'd3) ? ST_GATHER : ST_COPY;
                end
            ST_READ:   state_next = ST_IDLE;
            ST_GATHER: if (k_reg == 4'd9) state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_FORCE;
            ST_FORCE:  state_next = ST_MUL_S;
            ST_MUL_S:  state_next = ST_MUL_V;
            ST_MUL_V:  state_next = ST_ACCEL;
            ST_ACCEL:  state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_VEL;
            ST_VEL:    state_next = ST_MUL_N;
            ST_MUL_N:  state_next = ST_NEXT;
            ST_NEXT:   state_next = (last_y && last_x) ? ST_COPY : ST_GATHER;
            ST_COPY:
                if (copy_idx_reg == copy_len && !copy_pend_reg) state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            copy_idx_reg  <= '0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            // Walk the nine neighbor slots, then wait for the last read
            if (state_reg == ST_GATHER)
            begin
                k_reg <= (k_reg == 4'd9) ? 4'd0 : k_reg + 1'b1;
            end
            // Issue a copy read each cycle and write it back in the cycle after
            if (state_reg == ST_COPY)
            begin
                if (copy_idx_reg != copy_len)
                begin
                    copy_idx_reg  <= copy_idx_reg + 1'b1;
                    copy_pend_reg <= 1'b1;
                end
                else
                begin
                    copy_pend_reg <= 1'b0;
                end
            end
            else
            begin
                copy_idx_reg  <= '0;
                copy_pend_reg <= 1'b0;
            end
            // Raise a result, drop it once taken
            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            else if ((in_fire && in_op != OP_READ && in_op != OP_STEP) ||
                     state_reg == ST_READ || state_reg == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    logic [DATA_W-1:0] out_value_reg;
    logic              out_sat_reg;

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_idx_reg[ADDR_W-1:0];
        if (in_fire)
        begin
            dt_reg        <= in_dt;
            inside_reg    <= in_inside;
            sat_reg       <= 1'b0;
            x_reg         <= 7'd1;
            y_reg         <= 7'd1;
            out_value_reg <= '0;
            out_sat_reg   <= 1'b0;
        end
        if (state_reg == ST_READ)
        begin
            out_value_reg <= inside_reg ? next_q : '0;
        end
        if (state_reg == ST_DONE)
        begin
            out_sat_reg <= sat_reg;
        end
        // Accumulate neighbor sums as read data returns
        if (state_reg == ST_GATHER)
        begin
            if (k_reg == 4'd0)
            begin
                orth_reg <= '0;
                diag_reg <= '0;
            end
            else
            begin
                unique case (k_reg)
                    4'd1, 4'd3, 4'd7, 4'd9: diag_reg <= diag_reg + 34'(now_q);
                    4'd5:                   centre_reg <= now_q;
                    default:                orth_reg <= orth_reg + 34'(now_q);
                endcase
            end
            if (k_reg == 4'd5)
            begin
                vel_reg <= vel_q;
            end
        end
        if (state_reg == ST_FORCE)
        begin
            force_reg <= force_c.value;
            sat_reg   <= sat_reg | force_c.sat;
        end
        if (state_reg == ST_MUL_V)
        begin
            t_reg <= mrnd;
        end
        if (state_reg == ST_ACCEL)
        begin
            accel_reg <= accel_c.value;
            sat_reg   <= sat_reg | accel_c.sat;
        end
        if (state_reg == ST_VEL)
        begin
            vel_reg <= vel_c.value;
            sat_reg <= sat_reg | vel_c.sat;
        end
        // Advance to the next interior cell
        if (state_reg == ST_NEXT)
        begin
            sat_reg <= sat_reg | nxt_c.sat;
            if (last_y)
            begin
                y_reg <= 7'd1;
                x_reg <= x_reg + 1'b1;
            end
            else
            begin
                y_reg <= y_reg + 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_sat_reg, out_value_reg};

endmodule
`default_nettype wire

// ===== test/tb_grid_wave_spring_step_top.sv =====
// Self-checking bench for the wave grid step block: a directed table, then random phases.
// Predicts every read and step result from a local copy of the three grids, or takes it from the table.
// Depends on gws_pkg and grid_wave_spring_step_top.
`default_nettype none
module tb_grid_wave_spring_step_top;

    import gws_pkg::OP_READ;
    import gws_pkg::OP_WRITE;
    import gws_pkg::OP_STEP;
    import gws_pkg::REG_WIDTH;
    import gws_pkg::REG_HEIGHT;
    import gws_pkg::REG_SPRING;
    import gws_pkg::REG_DAMP;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int QBITS = 16;
    localparam int STALL_LIMIT = 1000000;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  code;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [31:0] val;
        logic [31:0] dt;
        bit          typed;
        logic [31:0] exp_val;
        bit          exp_sat;
    } row_t;

    typedef struct {
        logic [31:0] val;
        bit          sat;
    } amp_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;

    // Local copy of the block state
    int          amp_cur [GRID_COLS*GRID_ROWS];
    int          amp_nxt [GRID_COLS*GRID_ROWS];
    int          cell_vel [GRID_COLS*GRID_ROWS];
    logic [6:0]  cols_reg, rows_reg;
    logic [31:0] spring_reg, damp_reg;
    bit          clip_hit;

    amp_result_t pending_results [$];
    row_t        table_rows [$];
    int          fail_count = 0;
    int          n_reads = 0, n_writes = 0, n_steps = 0, n_sat = 0, n_checked = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          big_step_done = 1'b0;
    int          idle_cycles = 0;

    grid_wave_spring_step_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp to signed 32 bits and note the clip
    function automatic longint clamp_word(input longint v);
        if (v > 64'sd2147483647)
        begin
            clip_hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            clip_hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Shift right by the fraction width, rounding half up
    function automatic longint round_q(input longint v);
        return (v + (64'sd1 <<< (QBITS - 1))) >>> QBITS;
    endfunction

    // Run one time step over the interior cells, then copy next into current
    function automatic bit advance_grid(input logic [31:0] dt);
        int w, h, c, n;
        longint wd, centre, orth, diag, force_v, accel, vel, nxt, dtl, sg, dg;
        w = (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
        h = (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
        wd = (64'sd759250125 + (64'sd1 <<< (29 - QBITS))) >>> (30 - QBITS);
        dtl = longint'({32'd0, dt});
        sg = longint'({32'd0, spring_reg});
        dg = longint'({32'd0, damp_reg});
        clip_hit = 1'b0;
        for (int x = 1; x + 1 < w; x++)
        begin
            for (int y = 1; y + 1 < h; y++)
            begin
                c = x * h + y;
                centre = amp_cur[c];
                orth = 0;
                diag = 0;
                for (int a = -1; a <= 1; a++)
                begin
                    for (int b = -1; b <= 1; b++)
                    begin
                        n = (x + a) * h + (y + b);
                        if (a != 0 && b != 0)
                            diag += longint'(amp_cur[n]) - centre;
                        else
                            orth += longint'(amp_cur[n]) - centre;
                    end
                end
                force_v = clamp_word(orth + round_q(diag * wd));
                vel = cell_vel[c];
                accel = clamp_word(round_q(force_v * sg) - round_q(vel * dg));
                vel = clamp_word(vel + round_q(accel * dtl));
                nxt = clamp_word(centre + round_q(vel * dtl));
                cell_vel[c] = int'(vel);
                amp_nxt[c] = int'(nxt);
            end
        end
        for (int i = 0; i < w * h; i++)
            amp_cur[i] = amp_nxt[i];
        return clip_hit;
    endfunction

    // Predict the result of one accepted request and update the local state
    function automatic amp_result_t predict_request(input logic [1:0] op, input logic [5:0] x,
                                                    input logic [5:0] y, input logic [31:0] wv,
                                                    input logic [31:0] dt);
        amp_result_t r;
        int w, h;
        bit in_grid;
        w = (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
        h = (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
        in_grid = (int'(x) < w) && (int'(y) < h);
        r.val = '0;
        r.sat = 1'b0;
        case (op)
            OP_READ:
            begin
                n_reads++;
                if (in_grid)
                    r.val = amp_nxt[int'(x) * h + int'(y)];
            end
            OP_WRITE:
            begin
                n_writes++;
                if (in_grid)
                    amp_cur[int'(x) * h + int'(y)] = wv;
            end
            OP_STEP:
            begin
                n_steps++;
                r.sat = advance_grid(dt);
                if (r.sat)
                    n_sat++;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one request, with an optional gap, and hold until accepted
    task automatic send_request(input logic [1:0] op, input logic [5:0] x, input logic [5:0] y,
                                input logic [31:0] wv, input logic [31:0] dt, input bit typed,
                                input logic [31:0] exp_val, input bit exp_sat);
        amp_result_t r;
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, dt, wv, y, x, op};
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
        r = predict_request(op, x, y, wv, dt);
        if (typed)
        begin
            r.val = exp_val;
            r.sat = exp_sat;
        end
        pending_results.push_back(r);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        drain_block();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  cols_reg = data[6:0];
            REG_HEIGHT: rows_reg = data[6:0];
            REG_SPRING: spring_reg = data;
            default:    damp_reg = data;
        endcase
    endtask

    function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] data);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.code = idx;
        r.val = data;
        table_rows.push_back(r);
    endfunction

    function automatic void add_req(input logic [1:0] op, input logic [5:0] x,
                                    input logic [5:0] y, input logic [31:0] wv,
                                    input logic [31:0] dt, input bit typed,
                                    input logic [31:0] exp_val, input bit exp_sat);
        row_t r;
        r = '{is_cfg: 1'b0, code: op, x: x, y: y, val: wv, dt: dt, typed: typed,
              exp_val: exp_val, exp_sat: exp_sat};
        table_rows.push_back(r);
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0002_0000);
        endcase
    endfunction

    // Sink side: random stalls, plus one long hold-off on request
    always
    begin
        @(negedge clk);
        if (hold_req)
        begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (300) @(negedge clk);
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        amp_result_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result read_value=%h saturated=%b",
                         $time, m_tdata[31:0], m_tdata[32]);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                n_checked++;
                if (m_tdata[31:0] !== e.val)
                begin
                    $display("%0t: read_value expected %h actual %h", $time, e.val,
                             m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[32] !== e.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, e.sat,
                             m_tdata[32]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        row_t r;
        int nphase, nitems, w, h;
        logic [1:0] op;
        logic [5:0] x, y;
        logic [31:0] dt;
        for (int i = 0; i < GRID_COLS * GRID_ROWS; i++)
        begin
            amp_cur[i] = 0;
            amp_nxt[i] = 0;
            cell_vel[i] = 0;
        end
        cols_reg = '0;
        rows_reg = '0;
        spring_reg = '0;
        damp_reg = '0;

        // Directed table: reset values, small and oversized grids, extremes
        add_req(OP_READ, 0, 0, 0, 0, 1, 32'd0, 0);
        add_req(OP_NONE, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 0);
        add_req(OP_WRITE, 0, 0, 32'h7FFF_FFFF, 0, 1, 32'd0, 0);
        add_req(OP_STEP, 0, 0, 0, 32'hFFFF_FFFF, 1, 32'd0, 0);
        add_req(OP_READ, 0, 0, 0, 0, 1, 32'd0, 0);
        add_cfg(REG_WIDTH, 32'd2);
        add_cfg(REG_HEIGHT, 32'd64);
        add_req(OP_WRITE, 1, 5, 32'h1234_5678, 0, 0, 0, 0);
        add_req(OP_STEP, 0, 0, 0, 32'h0001_0000, 1, 32'd0, 0);
        add_req(OP_READ, 1, 5, 0, 0, 1, 32'd0, 0);
        add_cfg(REG_WIDTH, 32'd4);
        add_cfg(REG_HEIGHT, 32'd4);
        add_cfg(REG_SPRING, 32'h0001_0000);
        add_cfg(REG_DAMP, 32'h0000_2000);
        add_req(OP_WRITE, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_req(OP_WRITE, 2, 2, 32'h8000_0000, 0, 0, 0, 0);
        add_req(OP_WRITE, 2, 1, 32'h0001_0000, 0, 0, 0, 0);
        add_req(OP_WRITE, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_req(OP_STEP, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
        add_req(OP_READ, 1, 1, 0, 0, 0, 0, 0);
        add_req(OP_READ, 2, 2, 0, 0, 0, 0, 0);
        add_req(OP_READ, 4, 0, 0, 0, 1, 32'd0, 0);
        add_req(OP_STEP, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        add_req(OP_READ, 1, 2, 0, 0, 0, 0, 0);
        add_req(OP_READ, 0, 6'h3F, 0, 0, 1, 32'd0, 0);
        add_cfg(REG_SPRING, 32'hFFFF_FFFF);
        add_cfg(REG_DAMP, 32'hFFFF_FFFF);
        add_req(OP_STEP, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        add_req(OP_READ, 2, 1, 0, 0, 0, 0, 0);
        add_cfg(REG_WIDTH, 32'hFFFF_FF7F);
        add_cfg(REG_HEIGHT, 32'd127);
        add_req(OP_WRITE, 6'h3F, 6'h3F, 32'h8000_0000, 0, 0, 0, 0);
        add_req(OP_WRITE, 32, 32, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_req(OP_STEP, 0, 0, 0, 32'h0000_0100, 0, 0, 0);
        add_req(OP_READ, 6'h3F, 6'h3F, 0, 0, 0, 0, 0);
        add_req(OP_READ, 32, 33, 0, 0, 0, 0, 0);

        // Hold reset, then walk the table
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (table_rows[i])
        begin
            r = table_rows[i];
            if (r.is_cfg)
                write_reg(r.code, r.val);
            else
                send_request(r.code, r.x, r.y, r.val, r.dt, r.typed, r.exp_val, r.exp_sat);
        end

        // Random phases: mostly small grids, a random mix of writes, steps and reads
        for (nphase = 0; nphase < 8; nphase++)
        begin
            w = $urandom_range(0, 9);
            h = $urandom_range(0, 9);
            if (nphase == 5)
                w = 64;
            write_reg(REG_WIDTH, {25'($urandom_range(0, 32'h1FF_FFFF)), 7'(w)});
            write_reg(REG_HEIGHT, {25'($urandom_range(0, 32'h1FF_FFFF)), 7'(h)});
            write_reg(REG_SPRING, pick_gain());
            write_reg(REG_DAMP, pick_gain());
            if (nphase == 2)
                hold_req = 1'b1;
            if (nphase == 7)
                quiet = 1'b1;
            nitems = 12;
            for (int k = 0; k < nitems; k++)
            begin
                case ($urandom_range(0, 19))
                    0:                      op = OP_NONE;
                    1, 2, 3, 4, 5, 6, 7, 8: op = OP_WRITE;
                    9, 10, 11, 12:          op = OP_STEP;
                    default:                op = OP_READ;
                endcase
                // Keep the large grid to a single step
                if (op == OP_STEP && w * h > 100)
                begin
                    if (big_step_done)
                        op = OP_READ;
                    big_step_done = 1'b1;
                end
                if ($urandom_range(0, 7) == 0 || w == 0 || h == 0)
                begin
                    x = 6'($urandom);
                    y = 6'($urandom);
                end
                else
                begin
                    x = 6'($urandom_range(0, (w > 64 ? 64 : w) - 1));
                    y = 6'($urandom_range(0, h - 1));
                end
                dt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
                send_request(op, x, y, $urandom, dt, 0, 0, 0);
            end
        end

        drain_block();
        repeat (20) @(posedge clk);
        $display("Covered %0d reads, %0d writes, %0d steps (%0d saturating), %0d results checked",
                 n_reads, n_writes, n_steps, n_sat, n_checked);
        $display("Grids from empty to 64x64 and oversized, gains and time steps at extremes");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
